### design/slcp_pkg.sv
// ----------------------------------------------------------------------------
// slcp_pkg
// Shared types and constants for the status LED color pattern block.
// ----------------------------------------------------------------------------
`default_nettype none

package slcp_pkg;

	// Display modes, as shown on the result's mode field
	typedef enum logic [1:0] {
		MODE_NORMAL   = 2'd0,
		MODE_LINK_ERR = 2'd1,
		MODE_SYNC_ERR = 2'd2,
		MODE_WATERING = 2'd3
	} mode_t;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_BOOT_TIME   = 2'd0,
		REG_GRACE_TIME  = 2'd1,
		REG_BLINK_HALF  = 2'd2,
		REG_BREATH_PER  = 2'd3
	} reg_idx_t;

	localparam logic [31:0] BOOT_TIME_RST  = 32'd0;
	localparam logic [31:0] GRACE_TIME_RST = 32'd30000;
	localparam logic [15:0] BLINK_HALF_RST = 16'd500;
	localparam logic [15:0] BREATH_PER_RST = 16'd3000;

	localparam logic [7:0] LVL_MAX        = 8'd255;
	localparam logic [7:0] LVL_BREATH_MIN = 8'd18;
	localparam logic [7:0] LVL_DIM        = 8'd12;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        link_up;
		logic        time_synced;
		logic        watering_on;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_compare;
		logic [7:0] green_compare;
		logic [7:0] blue_compare;
		mode_t      mode;
	} out_item_t;

	// Classified item handed from the front end to the back end
	typedef struct packed {
		logic [31:0] now_ms;
		mode_t       mode;
	} mid_item_t;

	localparam int MID_W = $bits(mid_item_t);

	typedef logic [255:0][7:0] breath_lut_t;

	// Map a raw 0..255 triangle level into LVL_BREATH_MIN..LVL_MAX
	function automatic breath_lut_t build_breath_lut();
		breath_lut_t lut;
		for (int i = 0; i < 256; i++) begin
			lut[i] = 8'(int'(LVL_BREATH_MIN) + (i * (255 - 18)) / 255);
		end
		return lut;
	endfunction

	localparam breath_lut_t BREATH_LUT = build_breath_lut();

endpackage

`default_nettype wire

### design/slcp_fifo.sv
// ----------------------------------------------------------------------------
// slcp_fifo
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_fifo #(
	parameter int W     = 34,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### design/slcp_div.sv
// ----------------------------------------------------------------------------
// slcp_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_div #(
	parameter int N  = 32,
	parameter int D  = 16,
	parameter int SW = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [N-1:0]  dividend,
	input  wire logic [D-1:0]  divisor,
	input  wire logic [SW-1:0] in_side,
	output logic               out_valid,
	output logic [N-1:0]       quot,
	output logic [D-1:0]       rem,
	output logic [SW-1:0]      out_side
);

	logic [N-1:0]  valid_s;
	logic [D-1:0]  rem_s  [N];
	logic [N-1:0]  dq_s   [N];
	logic [SW-1:0] side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [D-1:0]  rem_prev;
		logic [N-1:0]  dq_prev;
		logic [SW-1:0] side_prev;
		logic          valid_prev;
		logic [D:0]    trial;
		logic [D:0]    diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_prev   = '0;
			assign dq_prev    = dividend;
			assign side_prev  = in_side;
			assign valid_prev = in_valid;
		end else begin : g_next
			assign rem_prev   = rem_s[k-1];
			assign dq_prev    = dq_s[k-1];
			assign side_prev  = side_s[k-1];
			assign valid_prev = valid_s[k-1];
		end

		// shift in the next dividend bit, subtract if it fits
		assign trial = {rem_prev, dq_prev[N-1]};
		assign diff  = trial - {1'b0, divisor};
		assign ge    = (trial >= {1'b0, divisor});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[D-1:0] : trial[D-1:0];
				dq_s[k]   <= {dq_prev[N-2:0], ge};
				side_s[k] <= side_prev;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_prev;
			end
		end
	end

	assign out_valid = valid_s[N-1];
	assign quot      = dq_s[N-1];
	assign rem       = rem_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

`default_nettype wire

### design/slcp_front.sv
// ----------------------------------------------------------------------------
// slcp_front
// Accept input beats and classify them into a display mode.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire slcp_pkg::in_item_t in_item,
	input  wire logic [31:0]      boot_time,
	input  wire logic [31:0]      grace_time,
	output logic                  out_valid,
	output slcp_pkg::mid_item_t   out_item,
	input  wire logic             out_ready
);

	import slcp_pkg::*;

	logic        valid_s1;
	mid_item_t   item_s1;
	logic [31:0] since_boot;
	logic        grace_over;
	mode_t       mode_nxt;

	assign since_boot = in_item.now_ms - boot_time;
	assign grace_over = (since_boot >= grace_time);

	always_comb begin
		if (grace_over && !in_item.link_up) begin
			mode_nxt = MODE_LINK_ERR;
		end else if (grace_over && !in_item.time_synced) begin
			mode_nxt = MODE_SYNC_ERR;
		end else if (in_item.watering_on) begin
			mode_nxt = MODE_WATERING;
		end else begin
			mode_nxt = MODE_NORMAL;
		end
	end

	assign full      = valid_s1 && !out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			item_s1.now_ms <= in_item.now_ms;
			item_s1.mode   <= mode_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || out_ready) begin
			valid_s1 <= push;
		end
	end

endmodule

`default_nettype wire

### design/slcp_back.sv
// ----------------------------------------------------------------------------
// slcp_back
// Compute blink phase and breathing level, form the PWM compare values.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire slcp_pkg::mid_item_t in_item,
	output logic                     in_pop,
	input  wire logic [15:0]         blink_div,
	input  wire logic [15:0]         period,
	output logic                     out_valid,
	output slcp_pkg::out_item_t      out_item,
	input  wire logic                out_pop
);

	import slcp_pkg::*;

	logic        en;
	logic        a_valid;
	logic [31:0] blink_q;
	logic [1:0]  a_side;
	logic [15:0] phase;
	logic [14:0] half;
	logic [15:0] tri_x;
	logic [23:0] tri_x24;

	logic        valid_sa;
	logic [23:0] num_sa;
	mode_t       mode_sa;
	logic        odd_sa;

	logic        b_valid;
	logic [23:0] raw_q;
	logic [2:0]  b_side;
	logic [7:0]  raw8;
	logic [7:0]  level;
	mode_t       b_mode;
	out_item_t   res;

	logic        out_valid_q;
	out_item_t   out_item_q;

	// whole pipeline holds while a finished result waits
	assign en     = !out_valid_q || out_pop;
	assign in_pop = en && in_valid;

	slcp_div #(.N(32), .D(16), .SW(2)) u_blink_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.dividend (in_item.now_ms),
		.divisor  (blink_div),
		.in_side  (in_item.mode),
		.out_valid(a_valid),
		.quot     (blink_q),
		.rem      (),
		.out_side (a_side)
	);

	slcp_div #(.N(32), .D(16), .SW(1)) u_phase_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.dividend (in_item.now_ms),
		.divisor  (period),
		.in_side  (1'b0),
		.out_valid(),
		.quot     (),
		.rem      (phase),
		.out_side ()
	);

	// fold the phase into a rising/falling triangle, scale by 255
	assign half    = period[15:1];
	assign tri_x   = (phase < {1'b0, half}) ? phase : (period - phase);
	assign tri_x24 = {8'd0, tri_x};

	always_ff @(posedge clk) begin
		if (en) begin
			num_sa  <= (tri_x24 << 8) - tri_x24;
			mode_sa <= mode_t'(a_side);
			odd_sa  <= blink_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sa <= 1'b0;
		end else if (en) begin
			valid_sa <= a_valid;
		end
	end

	slcp_div #(.N(24), .D(15), .SW(3)) u_level_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_sa),
		.dividend (num_sa),
		.divisor  (half),
		.in_side  ({mode_sa, odd_sa}),
		.out_valid(b_valid),
		.quot     (raw_q),
		.rem      (),
		.out_side (b_side)
	);

	assign raw8   = (|raw_q[23:8]) ? LVL_MAX : raw_q[7:0];
	assign level  = BREATH_LUT[raw8];
	assign b_mode = mode_t'(b_side[2:1]);

	always_comb begin
		res.mode          = b_mode;
		res.green_compare = LVL_MAX;
		res.red_compare   = LVL_MAX;
		res.blue_compare  = LVL_MAX;
		case (b_mode)
			MODE_LINK_ERR, MODE_SYNC_ERR: begin
				res.red_compare = b_side[0] ? LVL_MAX : 8'd0;
			end
			MODE_WATERING: begin
				res.blue_compare = LVL_MAX - level;
			end
			MODE_NORMAL: begin
				res.blue_compare = LVL_MAX - LVL_DIM;
			end
			default: begin
				res.blue_compare = LVL_MAX;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= b_valid;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

### design/status_led_color_pattern.sv
// Path from the accepting edge until the result shows: front stage, queue,
//   32-stage divider, fold/scale stage, 24-stage divider, output register.
// Throughput: one beat per cycle in and out while nothing stalls; each
//   divider stage retires one quotient bit per cycle, so a new item enters
//   the divider every cycle unless a waiting result holds the pipeline.
// Reset: arst_n clears all valid state and reloads the register defaults.
// ----------------------------------------------------------------------------
// status_led_color_pattern
// Picks the LED display mode from time, link, sync and watering status
// and produces active-low PWM compare values for red, green and blue.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_color_pattern #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input queue side
	input  wire logic                push,
	output logic                     full,
	input  wire slcp_pkg::in_item_t  in_data,
	// result queue side
	output logic                     empty,
	input  wire logic                pop,
	output slcp_pkg::out_item_t      out_data,
	// configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	import slcp_pkg::*;

	// Configuration registers
	logic [31:0] boot_time_q;
	logic [31:0] grace_time_q;
	logic [15:0] blink_half_q;
	logic [15:0] breath_per_q;

	reg_idx_t    reg_idx;
	logic        cfg_wr;

	// Effective divisors: zero blink half period acts as one,
	// a breathing period below two acts as two
	logic [15:0] blink_div;
	logic [15:0] period;

	// Front to queue
	logic        fr_valid;
	mid_item_t   fr_item;
	logic        q_full;

	// Queue to back
	mid_item_t   q_item;
	logic [MID_W-1:0] q_rdata;
	logic        q_empty;
	logic        bk_pop;
	logic        bk_valid;

	// Back to result side
	logic        empty_n;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_time_q  <= BOOT_TIME_RST;
			grace_time_q <= GRACE_TIME_RST;
			blink_half_q <= BLINK_HALF_RST;
			breath_per_q <= BREATH_PER_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_BOOT_TIME:  boot_time_q  <= pwdata;
				REG_GRACE_TIME: grace_time_q <= pwdata;
				REG_BLINK_HALF: blink_half_q <= pwdata[15:0];
				REG_BREATH_PER: breath_per_q <= pwdata[15:0];
				default: begin
					boot_time_q <= boot_time_q;
				end
			endcase
		end
	end

	// Read back the register at the addressed slot
	always_comb begin
		case (reg_idx)
			REG_BOOT_TIME:  prdata = boot_time_q;
			REG_GRACE_TIME: prdata = grace_time_q;
			REG_BLINK_HALF: prdata = {16'd0, blink_half_q};
			REG_BREATH_PER: prdata = {16'd0, breath_per_q};
			default:        prdata = '0;
		endcase
	end

	assign blink_div = (blink_half_q == 16'd0) ? 16'd1 : blink_half_q;
	assign period    = (breath_per_q < 16'd2) ? 16'd2 : breath_per_q;

	// Front: accept beats, resolve the display mode
	slcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_data),
		.boot_time (boot_time_q),
		.grace_time(grace_time_q),
		.out_valid (fr_valid),
		.out_item  (fr_item),
		.out_ready (!q_full)
	);

	// Queue: lets front and back stall on their own
	slcp_fifo #(.W(MID_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fr_valid),
		.wdata (fr_item),
		.full  (q_full),
		.pop   (bk_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign q_item   = mid_item_t'(q_rdata);
	assign bk_valid = !q_empty;

	// Back: blink phase, breathing level and compare values
	slcp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bk_valid),
		.in_item  (q_item),
		.in_pop   (bk_pop),
		.blink_div(blink_div),
		.period   (period),
		.out_valid(empty_n),
		.out_item (out_data),
		.out_pop  (pop)
	);

	assign empty = !empty_n;

endmodule

`default_nettype wire

### design/slcp_checker.sv
// ----------------------------------------------------------------------------
// slcp_checker
// Port-level checks on the result side of the LED pattern block.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                empty,
	input wire logic                pop,
	input wire slcp_pkg::out_item_t out_data
);

	import slcp_pkg::*;

	// A waiting result holds until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_data)))
		else $error("result changed while waiting");

	a_green: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_data.green_compare == LVL_MAX))
		else $error("green compare not off");

	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (out_data.mode == MODE_LINK_ERR || out_data.mode == MODE_SYNC_ERR))
		|-> (out_data.blue_compare == LVL_MAX &&
			(out_data.red_compare == LVL_MAX || out_data.red_compare == 8'd0)))
		else $error("bad error blink colors");

	a_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.mode == MODE_NORMAL)
		|-> (out_data.red_compare == LVL_MAX &&
			out_data.blue_compare == LVL_MAX - LVL_DIM))
		else $error("bad normal colors");

	a_water: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.mode == MODE_WATERING)
		|-> (out_data.red_compare == LVL_MAX &&
			out_data.blue_compare <= LVL_MAX - LVL_BREATH_MIN))
		else $error("breathing level out of range");

endmodule

bind status_led_color_pattern slcp_checker u_slcp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.empty   (empty),
	.pop     (pop),
	.out_data(out_data)
);

`default_nettype wire
